@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl files
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every edge outside reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/ddt_pkg.sv @@
// types, codes and constants of the discrete distribution table
// no dependencies
`default_nettype none
package ddt_pkg;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int VALUE_BITS      = 32;
    localparam int WEIGHT_IN_BITS  = 16;
    localparam int UNIT_BITS       = 17;
    localparam int FRAC_BITS       = 16;
    localparam int CUM_BITS        = 24;
    localparam int PROD_BITS       = UNIT_BITS + CUM_BITS;

    localparam logic [UNIT_BITS-1:0] UNIT_ONE = UNIT_BITS'(1 << FRAC_BITS);
    localparam logic [CUM_BITS-1:0]  CUM_MAX  = '1;

    localparam logic [2:0] REQ_CLEAR   = 3'd0;
    localparam logic [2:0] REQ_LOAD    = 3'd1;
    localparam logic [2:0] REQ_BUILD   = 3'd2;
    localparam logic [2:0] REQ_SAMPLE  = 3'd3;
    localparam logic [2:0] REQ_INVERSE = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BEYOND = 2'd3;

    typedef struct packed {
        logic [2:0]                   req_type;
        logic signed [VALUE_BITS-1:0] value;
        logic [WEIGHT_IN_BITS-1:0]    weight;
        logic [UNIT_BITS-1:0]         unit;
    } ddt_req_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value_out;
        logic [UNIT_BITS-1:0]         unit_out;
        logic [1:0]                   status;
    } ddt_rsp_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [CUM_BITS-1:0]   cum;
    } ddt_entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RAW_RD,
        S_INS_START,
        S_INS,
        S_INS_PUT,
        S_MRG_RD,
        S_MRG,
        S_MRG_END,
        S_SRCH,
        S_SRCH_CMP,
        S_FIN_RD,
        S_FIN,
        S_DIV,
        S_RESP
    } ddt_state_t;

    function automatic logic [VALUE_BITS-1:0] order_key(input logic [VALUE_BITS-1:0] v);
        return v ^ {1'b1, {(VALUE_BITS-1){1'b0}}};
    endfunction

endpackage
`default_nettype wire

@@ rtl/ddt_ram.sv @@
// simple dual port memory, one write and one registered read per cycle
// no dependencies
`default_nettype none
module ddt_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ rtl/ddt_div.sv @@
// restoring divider, one quotient bit per cycle
// depends on nothing but its parameters
`default_nettype none
module ddt_div #(
    parameter int NUM_BITS = 41,
    parameter int DEN_BITS = 24
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [NUM_BITS-1:0] num,
    input  wire logic [DEN_BITS-1:0] den,
    output logic                     busy,
    output logic      [NUM_BITS-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] quo_reg, quo_next;
    logic [DEN_BITS-1:0] rem_reg, rem_next;
    logic [DEN_BITS-1:0] den_reg, den_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic [DEN_BITS:0]   rem_sh;
    logic [DEN_BITS+1:0] diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[NUM_BITS-1]};
        diff      = {1'b0, rem_sh} - {2'b00, den_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CNT_W'(NUM_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[DEN_BITS+1])
            begin
                rem_next = diff[DEN_BITS-1:0];
                quo_next = {quo_reg[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DEN_BITS-1:0];
                quo_next = {quo_reg[NUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule
`default_nettype wire

@@ rtl/discrete_distribution_table.sv @@
// Discrete distribution table: load value/weight pairs, build a sorted table of
// distinct values with cumulative weights, then sample by unit fraction or look up
// the cumulative fraction of a value. One request is worked at a time; a new
// request is taken as soon as the previous one has handed its result to the
// output register. Sample time is set by the binary search over the table memory
// (each probe reads an entry, then compares the registered data), and inverse
// time by the same search and the serial divider. Build time is set by the
// insertion sort running in place in the table memory over the n loaded entries.
// No clearing pass is needed after reset.
// depends on ddt_pkg, ddt_ram, ddt_div and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module discrete_distribution_table
    import ddt_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire ddt_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output ddt_rsp_t      rsp
);

    localparam int AW   = $clog2(MAX_ENTRIES);
    localparam int CW   = AW + 1;
    localparam int RWB  = (WEIGHT_BITS < WEIGHT_IN_BITS) ? WEIGHT_BITS : WEIGHT_IN_BITS;
    localparam int RAWW = VALUE_BITS + RWB;
    localparam int TABW = VALUE_BITS + CUM_BITS;

    ddt_state_t            state_reg, state_next;
    ddt_req_t              req_reg, req_next;
    logic [CW-1:0]         raw_count_reg, raw_count_next;
    logic [CW-1:0]         distinct_reg, distinct_next;
    logic [CUM_BITS-1:0]   total_reg, total_next;
    logic                  built_reg, built_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [CW-1:0]         pos_reg, pos_next;
    logic [CW-1:0]         lo_reg, lo_next;
    logic [CW-1:0]         hi_reg, hi_next;
    logic [CUM_BITS-1:0]   cum_reg, cum_next;
    logic [VALUE_BITS-1:0] last_reg, last_next;
    logic [VALUE_BITS-1:0] ins_val_reg, ins_val_next;
    logic [CUM_BITS-1:0]   ins_wt_reg, ins_wt_next;
    logic [PROD_BITS-1:0]  target_reg, target_next;
    ddt_rsp_t              res_reg, res_next;
    ddt_rsp_t              rsp_reg, rsp_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    logic                  raw_we;
    logic [AW-1:0]         raw_waddr, raw_raddr;
    logic [RAWW-1:0]       raw_wdata, raw_rdata;
    logic                  tab_we;
    logic [AW-1:0]         tab_waddr, tab_raddr;
    ddt_entry_t            tab_wdata, tab_rdata;

    logic                  div_start, div_busy;
    logic [PROD_BITS-1:0]  div_num, div_quo;

    logic [UNIT_BITS-1:0]  unit_cl;
    logic [CUM_BITS:0]     cum_sum;
    logic [CUM_BITS-1:0]   cum_sat;
    logic [CW:0]           mid_sum;
    logic                  pred;
    logic                  ins_done;
    logic                  rsp_free;

    ddt_ram #(.WIDTH(RAWW), .DEPTH(MAX_ENTRIES)) u_raw (
        .clk   (clk),
        .we    (raw_we),
        .waddr (raw_waddr),
        .wdata (raw_wdata),
        .raddr (raw_raddr),
        .rdata (raw_rdata)
    );

    ddt_ram #(.WIDTH(TABW), .DEPTH(MAX_ENTRIES)) u_tab (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    ddt_div #(.NUM_BITS(PROD_BITS), .DEN_BITS(CUM_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (total_reg),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            raw_count_reg <= '0;
            distinct_reg  <= '0;
            total_reg     <= '0;
            built_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            raw_count_reg <= raw_count_next;
            distinct_reg  <= distinct_next;
            total_reg     <= total_next;
            built_reg     <= built_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        idx_reg     <= idx_next;
        pos_reg     <= pos_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        cum_reg     <= cum_next;
        last_reg    <= last_next;
        ins_val_reg <= ins_val_next;
        ins_wt_reg  <= ins_wt_next;
        target_reg  <= target_next;
        res_reg     <= res_next;
        rsp_reg     <= rsp_next;
    end

    always_comb
    begin
        unit_cl  = (req.unit > UNIT_ONE) ? UNIT_ONE : req.unit;
        cum_sum  = {1'b0, cum_reg} + {1'b0, tab_rdata.cum};
        cum_sat  = cum_sum[CUM_BITS] ? CUM_MAX : cum_sum[CUM_BITS-1:0];
        mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
        rsp_free = !rsp_valid_reg || !rsp_stall;
        ins_done = (idx_reg + 1'b1) == raw_count_reg;
        if (req_reg.req_type == REQ_SAMPLE)
        begin
            pred = {1'b0, tab_rdata.cum, {FRAC_BITS{1'b0}}} >= target_reg;
        end
        else
        begin
            pred = order_key(tab_rdata.value) >= order_key(req_reg.value);
        end
        div_num = {1'b0, tab_rdata.cum, {FRAC_BITS{1'b0}}}
                + PROD_BITS'(total_reg >> 1);

        state_next     = state_reg;
        req_next       = req_reg;
        raw_count_next = raw_count_reg;
        distinct_next  = distinct_reg;
        total_next     = total_reg;
        built_next     = built_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        cum_next       = cum_reg;
        last_next      = last_reg;
        ins_val_next   = ins_val_reg;
        ins_wt_next    = ins_wt_reg;
        target_next    = target_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        req_stall      = (state_reg != S_IDLE);
        raw_we         = 1'b0;
        raw_waddr      = raw_count_reg[AW-1:0];
        raw_wdata      = {req.value, req.weight[RWB-1:0]};
        raw_raddr      = idx_reg[AW-1:0];
        tab_we         = 1'b0;
        tab_waddr      = pos_reg[AW-1:0];
        tab_wdata      = tab_rdata;
        tab_raddr      = idx_reg[AW-1:0];
        div_start      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    res_next   = '0;
                    state_next = S_RESP;
                    unique case (req.req_type)
                        REQ_CLEAR:
                        begin
                            raw_count_next = '0;
                            distinct_next  = '0;
                            total_next     = '0;
                            built_next     = 1'b0;
                        end
                        REQ_LOAD:
                        begin
                            if (raw_count_reg == CW'(MAX_ENTRIES))
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                raw_we         = 1'b1;
                                raw_count_next = raw_count_reg + 1'b1;
                            end
                        end
                        REQ_BUILD:
                        begin
                            idx_next   = '0;
                            pos_next   = '0;
                            cum_next   = '0;
                            state_next = (raw_count_reg == '0) ? S_MRG_END : S_RAW_RD;
                        end
                        REQ_SAMPLE, REQ_INVERSE:
                        begin
                            target_next = PROD_BITS'(unit_cl) * PROD_BITS'(total_reg);
                            lo_next     = '0;
                            hi_next     = (req.req_type == REQ_SAMPLE) ?
                                          distinct_reg - 1'b1 : distinct_reg;
                            if (!built_reg)
                            begin
                                res_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_SRCH;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RAW_RD:
            begin
                state_next = S_INS_START;
            end
            S_INS_START:
            begin
                ins_val_next = raw_rdata[RAWW-1:RWB];
                ins_wt_next  = CUM_BITS'(raw_rdata[RWB-1:0]);
                pos_next     = idx_reg;
                if (idx_reg == '0)
                begin
                    tab_we     = 1'b1;
                    tab_waddr  = '0;
                    tab_wdata  = {raw_rdata[RAWW-1:RWB], CUM_BITS'(raw_rdata[RWB-1:0])};
                    idx_next   = ins_done ? '0 : idx_reg + 1'b1;
                    state_next = ins_done ? S_MRG_RD : S_RAW_RD;
                end
                else
                begin
                    tab_raddr  = AW'(idx_reg - 1'b1);
                    state_next = S_INS;
                end
            end
            S_INS:
            begin
                tab_we = 1'b1;
                if (order_key(tab_rdata.value) > order_key(ins_val_reg))
                begin
                    pos_next  = pos_reg - 1'b1;
                    tab_raddr = AW'(pos_reg - 2'd2);
                    if (pos_reg == CW'(1))
                    begin
                        state_next = S_INS_PUT;
                    end
                end
                else
                begin
                    tab_wdata  = {ins_val_reg, ins_wt_reg};
                    idx_next   = ins_done ? '0 : idx_reg + 1'b1;
                    state_next = ins_done ? S_MRG_RD : S_RAW_RD;
                end
            end
            S_INS_PUT:
            begin
                tab_we     = 1'b1;
                tab_waddr  = '0;
                tab_wdata  = {ins_val_reg, ins_wt_reg};
                idx_next   = ins_done ? '0 : idx_reg + 1'b1;
                state_next = ins_done ? S_MRG_RD : S_RAW_RD;
            end
            S_MRG_RD:
            begin
                pos_next   = '0;
                state_next = S_MRG;
            end
            S_MRG:
            begin
                tab_we    = 1'b1;
                tab_wdata = {tab_rdata.value, cum_sat};
                if (pos_reg != '0 && last_reg == tab_rdata.value)
                begin
                    tab_waddr = AW'(pos_reg - 1'b1);
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
                last_next = tab_rdata.value;
                cum_next  = cum_sat;
                idx_next  = idx_reg + 1'b1;
                tab_raddr = AW'(idx_reg + 1'b1);
                if (ins_done)
                begin
                    state_next = S_MRG_END;
                end
            end
            S_MRG_END:
            begin
                distinct_next   = pos_reg;
                total_next      = cum_reg;
                built_next      = (pos_reg != '0) && (cum_reg != '0);
                res_next.status = built_next ? ST_OK : ST_EMPTY;
                state_next      = S_RESP;
            end
            S_SRCH:
            begin
                pos_next  = mid_sum[CW:1];
                tab_raddr = mid_sum[AW:1];
                if (lo_reg < hi_reg)
                begin
                    state_next = S_SRCH_CMP;
                end
                else if (req_reg.req_type == REQ_SAMPLE || lo_reg < distinct_reg)
                begin
                    state_next = S_FIN_RD;
                end
                else
                begin
                    res_next.unit_out = UNIT_ONE;
                    res_next.status   = ST_BEYOND;
                    state_next        = S_RESP;
                end
            end
            S_SRCH_CMP:
            begin
                if (pred)
                begin
                    hi_next = pos_reg;
                end
                else
                begin
                    lo_next = pos_reg + 1'b1;
                end
                state_next = S_SRCH;
            end
            S_FIN_RD:
            begin
                tab_raddr  = lo_reg[AW-1:0];
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (req_reg.req_type == REQ_SAMPLE)
                begin
                    res_next.value_out = tab_rdata.value;
                    state_next         = S_RESP;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!div_busy)
                begin
                    res_next.unit_out = (div_quo > PROD_BITS'(UNIT_ONE)) ?
                                        UNIT_ONE : div_quo[UNIT_BITS-1:0];
                    state_next        = S_RESP;
                end
            end
            S_RESP:
            begin
                if (rsp_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ASSERT_ALWAYS(a_built_nonempty, !built_reg || (distinct_reg != '0 && total_reg != '0),
        "built table with no entries or zero total")
    `ASSERT_ALWAYS(a_distinct_le_raw, distinct_reg <= raw_count_reg,
        "more distinct values than loaded entries")
    `ASSERT_NEXT(a_resp_transfer, state_reg == S_RESP && rsp_free,
        rsp_valid_reg && state_reg == S_IDLE, "result not placed in output register")

endmodule
`default_nettype wire

@@ dv/discrete_distribution_table_tb.sv @@
// testbench for discrete_distribution_table: random load/build/sample/inverse traffic
// checked transfer by transfer against an in-bench table predictor
// depends on ddt_pkg and the discrete_distribution_table rtl
`timescale 1ns / 1ps
module discrete_distribution_table_tb;
    import ddt_pkg::*;

    localparam int NENT = 256;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    ddt_req_t req;
    logic     rsp_valid;
    logic     rsp_stall;
    ddt_rsp_t rsp;

    discrete_distribution_table dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    // predictor state
    logic [31:0] raw_val [NENT];
    logic [15:0] raw_wt [NENT];
    int unsigned raw_n;
    logic [31:0] tbl_val [NENT];
    logic [23:0] tbl_cum [NENT];
    int unsigned tbl_n;
    logic [23:0] tbl_total;
    bit          tbl_ok;

    ddt_req_t pending_reqs[$];
    ddt_rsp_t expected_rsps[$];
    int       mismatches;
    int       rsp_count;
    int       sample_count;
    int       inverse_count;
    bit       stim_done;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [1:0] build_table();
        logic [31:0] v [NENT];
        logic [15:0] w [NENT];
        logic [31:0] tv;
        logic [15:0] tw;
        longint      s;
        int          j;
        logic [23:0] cum;
        int unsigned cnt;
        cum = 0;
        cnt = 0;
        for (int i = 0; i < raw_n; i++)
        begin
            tv = raw_val[i];
            tw = raw_wt[i];
            j = i;
            while (j > 0 && order_key(v[j-1]) > order_key(tv))
            begin
                v[j] = v[j-1];
                w[j] = w[j-1];
                j--;
            end
            v[j] = tv;
            w[j] = tw;
        end
        for (int i = 0; i < raw_n; i++)
        begin
            s = longint'(cum) + longint'(w[i]);
            cum = (s > longint'(CUM_MAX)) ? CUM_MAX : s[23:0];
            if (cnt > 0 && tbl_val[cnt-1] == v[i])
                tbl_cum[cnt-1] = cum;
            else
            begin
                tbl_val[cnt] = v[i];
                tbl_cum[cnt] = cum;
                cnt++;
            end
        end
        tbl_n = cnt;
        tbl_total = cum;
        tbl_ok = (cnt != 0 && cum != 0);
        return tbl_ok ? ST_OK : ST_EMPTY;
    endfunction

    function automatic ddt_rsp_t predict_table(ddt_req_t r);
        ddt_rsp_t    o;
        logic [16:0] u;
        longint      target;
        longint      q;
        int unsigned i;
        o = '0;
        case (r.req_type)
            REQ_CLEAR:
            begin
                raw_n = 0;
                tbl_n = 0;
                tbl_total = 0;
                tbl_ok = 0;
            end
            REQ_LOAD:
            begin
                if (raw_n >= NENT)
                    o.status = ST_FULL;
                else
                begin
                    raw_val[raw_n] = r.value;
                    raw_wt[raw_n] = r.weight;
                    raw_n++;
                end
            end
            REQ_BUILD: o.status = build_table();
            REQ_SAMPLE:
            begin
                if (!tbl_ok)
                    o.status = ST_EMPTY;
                else
                begin
                    u = (r.unit > UNIT_ONE) ? UNIT_ONE : r.unit;
                    target = longint'(u) * longint'(tbl_total);
                    i = 0;
                    while (i + 1 < tbl_n && longint'(tbl_cum[i]) * 65536 < target)
                        i++;
                    o.value_out = tbl_val[i];
                end
            end
            REQ_INVERSE:
            begin
                if (!tbl_ok)
                    o.status = ST_EMPTY;
                else
                begin
                    i = 0;
                    while (i < tbl_n && order_key(tbl_val[i]) < order_key(r.value))
                        i++;
                    if (i >= tbl_n)
                    begin
                        o.status = ST_BEYOND;
                        o.unit_out = UNIT_ONE;
                    end
                    else
                    begin
                        q = (longint'(tbl_cum[i]) * 65536 + longint'(tbl_total / 2))
                            / longint'(tbl_total);
                        o.unit_out = (q > 65536) ? UNIT_ONE : q[16:0];
                    end
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic ddt_req_t make_req(logic [2:0] t, logic [31:0] v, logic [15:0] w,
                                          logic [16:0] u);
        ddt_req_t r;
        r.req_type = t;
        r.value = v;
        r.weight = w;
        r.unit = u;
        return r;
    endfunction

    task automatic add_req(input ddt_req_t r);
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    function automatic logic [31:0] rand_value(int pool);
        if (pool > 0 && $urandom_range(0, 3) != 0)
            return 32'($urandom_range(0, pool - 1)) << 16;
        return $urandom;
    endfunction

    function automatic logic [16:0] rand_unit();
        case ($urandom_range(0, 5))
            0: return 17'($urandom_range(0, 1)) << 16;
            1: return 17'($urandom_range(65537, 131071));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    // driver
    int req_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            req_gap <= 0;
        end
        else if (!req_valid || !req_stall)
        begin
            if (req_valid)
                expected_rsps.insert(expected_rsps.size(), predict_table(req));
            if (req_gap > 0)
            begin
                req_valid <= 1'b0;
                req_gap <= req_gap - 1;
            end
            else if (pending_reqs.size() > 0)
            begin
                req <= pending_reqs.pop_front();
                req_valid <= 1'b1;
                req_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // monitor
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        ddt_rsp_t e;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                rsp_count++;
                if (expected_rsps.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transfer: %h", rsp);
                end
                else
                begin
                    e = expected_rsps.pop_front();
                    if (e.value_out !== rsp.value_out || e.unit_out !== rsp.unit_out ||
                        e.status !== rsp.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp value %h unit %h st %0d, got %h %h %0d",
                                     e.value_out, e.unit_out, e.status,
                                     rsp.value_out, rsp.unit_out, rsp.status);
                    end
                end
                stall_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
                rsp_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    initial
    begin
        int nload;
        int pool;
        int items;
        int nq;
        rst_n = 1'b0;
        raw_n = 0;
        tbl_n = 0;
        tbl_total = 0;
        tbl_ok = 0;
        mismatches = 0;
        rsp_count = 0;
        sample_count = 0;
        inverse_count = 0;
        stim_done = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: queries before build, empty build, extremes, zero weight, duplicates
        add_req(make_req(REQ_SAMPLE, 0, 0, 0));
        add_req(make_req(REQ_INVERSE, 0, 0, 0));
        add_req(make_req(REQ_BUILD, 0, 0, 0));
        add_req(make_req(REQ_LOAD, 32'h7fffffff, 0, 0));
        add_req(make_req(REQ_BUILD, 0, 0, 0));
        add_req(make_req(REQ_LOAD, 32'h80000000, 16'hffff, 17'h1ffff));
        add_req(make_req(REQ_LOAD, 32'h00010000, 16'hffff, 0));
        add_req(make_req(REQ_LOAD, 32'h00010000, 16'd1, 0));
        add_req(make_req(3'd5, 32'hffffffff, 16'hffff, 17'h1ffff));
        add_req(make_req(3'd7, 0, 0, 0));
        add_req(make_req(REQ_BUILD, 0, 0, 0));
        add_req(make_req(REQ_SAMPLE, 0, 0, 0));
        add_req(make_req(REQ_SAMPLE, 0, 0, UNIT_ONE));
        add_req(make_req(REQ_SAMPLE, 0, 0, 17'h1ffff));
        add_req(make_req(REQ_SAMPLE, 0, 0, 17'h08000));
        add_req(make_req(REQ_INVERSE, 32'h80000000, 0, 0));
        add_req(make_req(REQ_INVERSE, 32'h00010000, 0, 0));
        add_req(make_req(REQ_INVERSE, 32'h7fffffff, 0, 0));
        add_req(make_req(REQ_CLEAR, 0, 0, 0));
        add_req(make_req(REQ_INVERSE, 0, 0, 0));

        // one full table with an overflowing load, every weight at its maximum
        for (int i = 0; i < NENT + 1; i++)
            add_req(make_req(REQ_LOAD, $urandom, 16'hffff, 0));
        add_req(make_req(REQ_BUILD, 0, 0, 0));
        for (int i = 0; i < 10; i++)
            add_req(make_req(REQ_SAMPLE, 0, 0, rand_unit()));
        for (int i = 0; i < 10; i++)
            add_req(make_req(REQ_INVERSE, $urandom, 0, 0));

        // random sessions: clear, small loads, build, queries, some noise
        items = 0;
        while (items < 450)
        begin
            add_req(make_req(REQ_CLEAR, $urandom, 16'($urandom), 17'($urandom)));
            nload = $urandom_range(0, 12);
            pool = $urandom_range(1, 16);
            for (int i = 0; i < nload; i++)
                add_req(make_req(REQ_LOAD, rand_value(pool),
                    ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 2)) : 16'($urandom),
                    17'($urandom)));
            add_req(make_req(REQ_BUILD, $urandom, 16'($urandom), 17'($urandom)));
            nq = $urandom_range(2, 12);
            for (int i = 0; i < nq; i++)
            begin
                if ($urandom_range(0, 1))
                    add_req(make_req(REQ_SAMPLE, $urandom, 16'($urandom), rand_unit()));
                else
                    add_req(make_req(REQ_INVERSE, rand_value(pool + 1),
                                     16'($urandom), 17'($urandom)));
                items++;
            end
            if ($urandom_range(0, 7) == 0)
                add_req(make_req(3'($urandom_range(5, 7)), $urandom,
                                 16'($urandom), 17'($urandom)));
            items += nload + 2;
        end
        stim_done = 1;
    end

    initial
    begin
        wait (stim_done);
        wait (pending_reqs.size() == 0 && !req_valid && expected_rsps.size() == 0);
        repeat (200) @(posedge clk);
        $display("%0d responses checked over load, build, sample and inverse traffic",
                 rsp_count);
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("timeout");
        $display("Some tests failed");
        $finish;
    end

endmodule
